// ===== src/ilie_pkg.sv =====
`timescale 1ns / 1ps

package ilie_pkg;

    // Request operation codes
    localparam logic [2:0] MODE_APPEND    = 3'd0;
    localparam logic [2:0] MODE_OVERWRITE = 3'd1;
    localparam logic [2:0] MODE_INSERT    = 3'd2;
    localparam logic [2:0] MODE_ERASE     = 3'd3;
    localparam logic [2:0] MODE_READ      = 3'd4;
    localparam logic [2:0] MODE_CLEAR     = 3'd5;

    // Result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Fixed field widths of the request and response words
    localparam int MODE_W   = 3;
    localparam int POS_W    = 6;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 6;
    localparam int STATUS_W = 2;

    // Command broadcast to every cell of the row
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_WRITE  = 2'd1,
        CELL_INSERT = 2'd2,
        CELL_ERASE  = 2'd3
    } cell_op_t;

    // Outcome of one request, handed from the decoder to the response stage
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                read_ok;
    } req_outcome_t;

endpackage

// ===== src/ilie_if.sv =====
`timescale 1ns / 1ps

interface ilie_req_if;
    logic                          valid;
    logic                          ready;
    logic [ilie_pkg::MODE_W-1:0]   mode;
    logic [ilie_pkg::POS_W-1:0]    position;
    logic [ilie_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output mode, output position, output value, input ready);
    modport sink   (input valid, input mode, input position, input value, output ready);
endinterface

interface ilie_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ilie_pkg::VALUE_W-1:0]  read_word;
    logic [ilie_pkg::COUNT_W-1:0]  count;
    logic [ilie_pkg::STATUS_W-1:0] status;

    modport source (output valid, output read_word, output count, output status, input ready);
    modport sink   (input valid, input read_word, input count, input status, output ready);
endinterface

// ===== src/indexed_list_insert_erase.sv =====
`timescale 1ns / 1ps
// Response word: registered, offered in the cycle after its request.
// Throughput: one request word per cycle unless the response stalls;
// all cells move on one edge, so a shift costs no more than an overwrite.
// Reset: clears the list length and the response valid flag; the entry
// cells have no reset and hold nothing meaningful until written.
module indexed_list_insert_erase #(
    parameter int CAPACITY   = 32,
    parameter int WORD_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    ilie_req_if.sink          req,
    ilie_rsp_if.source        rsp
);

    // Length counter must hold CAPACITY itself
    localparam int CNT_W = $clog2(CAPACITY + 1);
    // Index width that addresses one entry
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    // Compare width wide enough for both position and length
    localparam int TGT_W = (CNT_W > ilie_pkg::POS_W) ? CNT_W : ilie_pkg::POS_W;
    // Common width for moving words between request, entries and response
    localparam int EXT_W = (WORD_WIDTH > ilie_pkg::VALUE_W) ? WORD_WIDTH : ilie_pkg::VALUE_W;

    logic [CNT_W-1:0]              fill_reg;
    logic [CNT_W-1:0]              fill_next;
    logic                          rsp_valid_reg;
    logic [ilie_pkg::VALUE_W-1:0]  read_word_reg;
    logic [ilie_pkg::VALUE_W-1:0]  read_word_next;
    logic [ilie_pkg::COUNT_W-1:0]  count_reg;
    logic [ilie_pkg::STATUS_W-1:0] status_reg;

    logic                   fire;
    ilie_pkg::cell_op_t     op;
    logic [TGT_W-1:0]       target;
    ilie_pkg::req_outcome_t outcome;

    logic [EXT_W-1:0]      value_ext;
    logic [WORD_WIDTH-1:0] value_word;
    logic [WORD_WIDTH-1:0] entry [CAPACITY];
    logic [IDX_W-1:0]      read_idx;
    logic [TGT_W-1:0]      pos_ext;
    logic [EXT_W-1:0]      read_ext;

    // Take a new word whenever the response register is empty or draining
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign fire      = req.valid && req.ready;

    // Keep the low WORD_WIDTH bits of the request value
    assign value_ext  = EXT_W'(req.value);
    assign value_word = value_ext[WORD_WIDTH-1:0];

    ilie_ctrl #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W),
        .TGT_W    (TGT_W)
    ) u_ctrl (
        .fire      (fire),
        .mode      (req.mode),
        .position  (req.position),
        .fill      (fill_reg),
        .op        (op),
        .target    (target),
        .fill_next (fill_next),
        .outcome   (outcome)
    );

    // Row of cells: each one sees its neighbours and the broadcast command.
    // Insert pulls from the left, erase pulls from the right.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [WORD_WIDTH-1:0] left_word;
        logic [WORD_WIDTH-1:0] right_word;

        if (i == 0)
        begin : g_first
            assign left_word = '0;
        end
        else
        begin : g_left
            assign left_word = entry[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_word = entry[i];
        end
        else
        begin : g_right
            assign right_word = entry[i+1];
        end

        ilie_cell #(
            .WORD_WIDTH (WORD_WIDTH),
            .TGT_W      (TGT_W),
            .SLOT       (i)
        ) u_cell (
            .clk    (clk),
            .op     (op),
            .target (target),
            .value  (value_word),
            .left   (left_word),
            .right  (right_word),
            .word   (entry[i])
        );
    end

    // Read port: only used when the position is below the length,
    // so the low index bits select the entry.
    assign pos_ext  = TGT_W'(req.position);
    assign read_idx = pos_ext[IDX_W-1:0];
    assign read_ext = EXT_W'(entry[read_idx]);

    always_comb
    begin
        if (outcome.read_ok)
            read_word_next = read_ext[ilie_pkg::VALUE_W-1:0];
        else
            read_word_next = '0;
    end

    // Length and response valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
                fill_reg <= fill_next;
            if (fire)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // Response payload: load with each accepted word, hold while stalled
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            read_word_reg <= read_word_next;
            count_reg     <= ilie_pkg::COUNT_W'(fill_next);
            status_reg    <= outcome.status;
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.read_word = read_word_reg;
    assign rsp.count     = count_reg;
    assign rsp.status    = status_reg;

endmodule

// ===== src/ilie_cell.sv =====
`timescale 1ns / 1ps

// One entry: hold own word or load value, left or right neighbour.
module ilie_cell #(
    parameter int WORD_WIDTH = 32,
    parameter int TGT_W      = 6,
    parameter int SLOT       = 0
) (
    input  logic                  clk,
    input  ilie_pkg::cell_op_t    op,
    input  logic [TGT_W-1:0]      target,
    input  logic [WORD_WIDTH-1:0] value,
    input  logic [WORD_WIDTH-1:0] left,
    input  logic [WORD_WIDTH-1:0] right,
    output logic [WORD_WIDTH-1:0] word
);

    logic [WORD_WIDTH-1:0] word_reg;
    logic [WORD_WIDTH-1:0] word_next;
    logic                  at_target;
    logic                  above_target;

    assign at_target    = (SLOT == int'(target));
    assign above_target = (SLOT > int'(target));

    always_comb
    begin
        word_next = word_reg;
        unique case (op)
            ilie_pkg::CELL_HOLD:
            begin
                word_next = word_reg;
            end
            ilie_pkg::CELL_WRITE:
            begin
                if (at_target)
                    word_next = value;
            end
            ilie_pkg::CELL_INSERT:
            begin
                if (at_target)
                    word_next = value;
                else if (above_target)
                    word_next = left;
            end
            ilie_pkg::CELL_ERASE:
            begin
                if (at_target || above_target)
                    word_next = right;
            end
            default:
            begin
                word_next = word_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

// ===== src/ilie_ctrl.sv =====
`timescale 1ns / 1ps

// Decode a request against the current length: pick the row command,
// the new length and the status.
module ilie_ctrl #(
    parameter int CAPACITY = 32,
    parameter int CNT_W    = 6,
    parameter int TGT_W    = 6
) (
    input  logic                          fire,
    input  logic [ilie_pkg::MODE_W-1:0]   mode,
    input  logic [ilie_pkg::POS_W-1:0]    position,
    input  logic [CNT_W-1:0]              fill,
    output ilie_pkg::cell_op_t            op,
    output logic [TGT_W-1:0]              target,
    output logic [CNT_W-1:0]              fill_next,
    output ilie_pkg::req_outcome_t        outcome
);

    logic [TGT_W-1:0]   pos_ext;
    logic [TGT_W-1:0]   fill_ext;
    logic               full;
    logic               in_range;
    logic               at_end;
    ilie_pkg::cell_op_t op_dec;

    assign pos_ext  = TGT_W'(position);
    assign fill_ext = TGT_W'(fill);
    assign full     = (fill == CNT_W'(CAPACITY));
    assign in_range = (pos_ext < fill_ext);
    assign at_end   = (pos_ext == fill_ext);

    always_comb
    begin
        op_dec          = ilie_pkg::CELL_HOLD;
        target          = pos_ext;
        fill_next       = fill;
        outcome.status  = ilie_pkg::ST_DONE;
        outcome.read_ok = 1'b0;
        unique case (mode)
            ilie_pkg::MODE_APPEND:
            begin
                if (full)
                    outcome.status = ilie_pkg::ST_FULL;
                else
                begin
                    op_dec    = ilie_pkg::CELL_INSERT;
                    target    = fill_ext;
                    fill_next = fill + 1'b1;
                end
            end
            ilie_pkg::MODE_OVERWRITE:
            begin
                if (in_range)
                    op_dec = ilie_pkg::CELL_WRITE;
                else if (!at_end)
                    outcome.status = ilie_pkg::ST_RANGE;
                else if (full)
                    outcome.status = ilie_pkg::ST_FULL;
                else
                begin
                    // overwrite just past the end behaves as append
                    op_dec    = ilie_pkg::CELL_INSERT;
                    fill_next = fill + 1'b1;
                end
            end
            ilie_pkg::MODE_INSERT:
            begin
                if (!in_range && !at_end)
                    outcome.status = ilie_pkg::ST_RANGE;
                else if (full)
                    outcome.status = ilie_pkg::ST_FULL;
                else
                begin
                    op_dec    = ilie_pkg::CELL_INSERT;
                    fill_next = fill + 1'b1;
                end
            end
            ilie_pkg::MODE_ERASE:
            begin
                if (!in_range)
                    outcome.status = ilie_pkg::ST_RANGE;
                else
                begin
                    op_dec    = ilie_pkg::CELL_ERASE;
                    fill_next = fill - 1'b1;
                end
            end
            ilie_pkg::MODE_READ:
            begin
                if (!in_range)
                    outcome.status = ilie_pkg::ST_RANGE;
                else
                    outcome.read_ok = 1'b1;
            end
            ilie_pkg::MODE_CLEAR:
            begin
                fill_next = '0;
            end
            default:
            begin
                fill_next = fill;
            end
        endcase
    end

    // Hold every cell unless a word is taken this cycle
    assign op = fire ? op_dec : ilie_pkg::CELL_HOLD;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

// Testbench for indexed_list_insert_erase.
//
// A shadow list in the testbench follows every request word that the block
// accepts and predicts its response word. Responses are compared field by
// field with the oldest prediction. Named test tasks run in turn: directed
// edge cases, a full-list pass, a long receiver hold-off, random mixed
// traffic with idling on both sides, and a final stretch with no idling.
module tb;

    localparam time CLK_PERIOD  = 20ns;
    localparam time RUN_LIMIT   = 8_000_000ns;
    localparam int  LIST_DEPTH  = 32;
    localparam int  HOLD_CYCLES = 150;
    localparam int  DRAIN_LIMIT = 2000;

    // Codes the block must treat as no-ops
    localparam logic [2:0] MODE_SPARE_LO = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [ilie_pkg::VALUE_W-1:0]  read_word;
        logic [ilie_pkg::COUNT_W-1:0]  count;
        logic [ilie_pkg::STATUS_W-1:0] status;
    } list_rsp_t;

    logic clk;
    logic rst_n;

    ilie_req_if req_if ();
    ilie_rsp_if rsp_if ();

    indexed_list_insert_erase #(
        .CAPACITY   (LIST_DEPTH),
        .WORD_WIDTH (ilie_pkg::VALUE_W)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // Shadow copy of the list contents and its length
    logic [ilie_pkg::VALUE_W-1:0] shadow_list [LIST_DEPTH];
    int                           shadow_len;

    list_rsp_t pending_rsp [$];

    int  fail_count;
    int  mode_seen [8];
    int  status_seen [4];
    int  peak_len;

    // Idling controls: sender gaps, receiver gaps, and the long hold-off
    bit  src_gaps;
    bit  sink_gaps;
    bit  hold_request;

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("tb failed");
        $finish;
    end

    // Work out the response to one accepted request and advance the shadow list.
    function automatic list_rsp_t apply_request(
        input logic [2:0]                   op,
        input logic [5:0]                   pos,
        input logic [ilie_pkg::VALUE_W-1:0] word
    );
        list_rsp_t r;
        int        p;
        r.read_word = '0;
        r.status    = ilie_pkg::ST_DONE;
        p           = int'(pos);
        case (op)
            ilie_pkg::MODE_APPEND:
            begin
                if (shadow_len >= LIST_DEPTH)
                    r.status = ilie_pkg::ST_FULL;
                else
                begin
                    shadow_list[shadow_len] = word;
                    shadow_len++;
                end
            end
            ilie_pkg::MODE_OVERWRITE:
            begin
                if (p > shadow_len)
                    r.status = ilie_pkg::ST_RANGE;
                else if (p < shadow_len)
                    shadow_list[p] = word;
                else if (shadow_len >= LIST_DEPTH)
                    r.status = ilie_pkg::ST_FULL;
                else
                begin
                    shadow_list[shadow_len] = word;
                    shadow_len++;
                end
            end
            ilie_pkg::MODE_INSERT:
            begin
                if (p > shadow_len)
                    r.status = ilie_pkg::ST_RANGE;
                else if (shadow_len >= LIST_DEPTH)
                    r.status = ilie_pkg::ST_FULL;
                else
                begin
                    for (int i = shadow_len; i > p; i--)
                        shadow_list[i] = shadow_list[i-1];
                    shadow_list[p] = word;
                    shadow_len++;
                end
            end
            ilie_pkg::MODE_ERASE:
            begin
                if (p >= shadow_len)
                    r.status = ilie_pkg::ST_RANGE;
                else
                begin
                    for (int i = p; i + 1 < shadow_len; i++)
                        shadow_list[i] = shadow_list[i+1];
                    shadow_len--;
                end
            end
            ilie_pkg::MODE_READ:
            begin
                if (p >= shadow_len)
                    r.status = ilie_pkg::ST_RANGE;
                else
                    r.read_word = shadow_list[p];
            end
            ilie_pkg::MODE_CLEAR:
                shadow_len = 0;
            default:
                ;
        endcase
        r.count = shadow_len[ilie_pkg::COUNT_W-1:0];
        return r;
    endfunction

    // Score both channels on the same edge: check the response word first,
    // then queue the prediction for the request word taken on this edge.
    always @(posedge clk)
    begin
        list_rsp_t want;
        list_rsp_t pred;
        if (rst_n)
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                if (pending_rsp.size() == 0)
                begin
                    $error("unexpected response word: read_word %h count %0d status %0d",
                           rsp_if.read_word, rsp_if.count, rsp_if.status);
                    fail_count++;
                end
                else
                begin
                    want = pending_rsp.pop_front();
                    if (rsp_if.read_word !== want.read_word)
                    begin
                        $error("read_word: expected %h, got %h",
                               want.read_word, rsp_if.read_word);
                        fail_count++;
                    end
                    if (rsp_if.count !== want.count)
                    begin
                        $error("count: expected %0d, got %0d", want.count, rsp_if.count);
                        fail_count++;
                    end
                    if (rsp_if.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp_if.status);
                        fail_count++;
                    end
                end
            end
            if (req_if.valid && req_if.ready)
            begin
                pred = apply_request(req_if.mode, req_if.position, req_if.value);
                pending_rsp.push_back(pred);
                mode_seen[req_if.mode]++;
                status_seen[pred.status]++;
                if (shadow_len > peak_len)
                    peak_len = shadow_len;
            end
        end
    end

    // Receiver: ready high by default, random stall bursts, and one long
    // hold-off counted here when a test asks for it.
    initial
    begin
        int unsigned stall;
        forever
        begin
            if (hold_request)
            begin
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else if (sink_gaps && $urandom_range(0, 6) == 0)
            begin
                stall = $urandom_range(1, 15);
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            else
            begin
                rsp_if.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Offer one request word and hold it until the block takes it. Valid is
    // left high on return so that back-to-back words need no second drive.
    task automatic send_word(input logic [2:0] op, input logic [5:0] pos,
                             input logic [ilie_pkg::VALUE_W-1:0] word);
        int unsigned gap;
        if (src_gaps && $urandom_range(0, 6) == 0)
        begin
            gap = $urandom_range(1, 15);
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid    <= 1'b1;
        req_if.mode     <= op;
        req_if.position <= pos;
        req_if.value    <= word;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
    endtask

    // Drop valid and wait until every pending response word has come back.
    task automatic wait_drained();
        int waited;
        waited = 0;
        req_if.valid <= 1'b0;
        while (pending_rsp.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        @(posedge clk);
    endtask

    // Empty-list rejections, overwrite and insert at the end, insert in front,
    // reads across the list, erase in the middle and at the end, spare codes,
    // clear, and a top position well past the capacity.
    task automatic test_edge_cases();
        send_word(ilie_pkg::MODE_READ,      6'd0,  32'h1234_5678);
        send_word(ilie_pkg::MODE_ERASE,     6'd0,  32'h0);
        send_word(ilie_pkg::MODE_OVERWRITE, 6'd1,  32'hFFFF_FFFF);
        send_word(ilie_pkg::MODE_INSERT,    6'd1,  32'hFFFF_FFFF);
        send_word(ilie_pkg::MODE_OVERWRITE, 6'd0,  32'hFFFF_FFFF);
        send_word(ilie_pkg::MODE_APPEND,    6'd63, 32'h0000_0000);
        send_word(ilie_pkg::MODE_INSERT,    6'd0,  32'hA5A5_A5A5);
        send_word(ilie_pkg::MODE_INSERT,    6'd3,  32'h0000_0001);
        send_word(ilie_pkg::MODE_INSERT,    6'd63, 32'h5A5A_5A5A);
        send_word(ilie_pkg::MODE_OVERWRITE, 6'd2,  32'h8000_0000);
        send_word(ilie_pkg::MODE_READ,      6'd0,  32'h0);
        send_word(ilie_pkg::MODE_READ,      6'd1,  32'h0);
        send_word(ilie_pkg::MODE_READ,      6'd2,  32'h0);
        send_word(ilie_pkg::MODE_READ,      6'd3,  32'hFFFF_FFFF);
        send_word(ilie_pkg::MODE_READ,      6'd4,  32'h0);
        send_word(ilie_pkg::MODE_READ,      6'd63, 32'h0);
        send_word(ilie_pkg::MODE_ERASE,     6'd1,  32'h0);
        send_word(ilie_pkg::MODE_ERASE,     6'd3,  32'h0);
        send_word(ilie_pkg::MODE_ERASE,     6'd2,  32'h0);
        send_word(MODE_SPARE_LO,            6'd63, 32'hFFFF_FFFF);
        send_word(MODE_SPARE_HI,            6'd0,  32'hFFFF_FFFF);
        send_word(ilie_pkg::MODE_READ,      6'd1,  32'h0);
        send_word(ilie_pkg::MODE_CLEAR,     6'd63, 32'hFFFF_FFFF);
        send_word(ilie_pkg::MODE_READ,      6'd0,  32'h0);
        send_word(ilie_pkg::MODE_APPEND,    6'd0,  32'hC0DE_0001);
        wait_drained();
    endtask

    // Fill the list to capacity, then hit every full and range rejection.
    task automatic test_full_list();
        send_word(ilie_pkg::MODE_CLEAR, 6'd0, 32'h0);
        for (int n = 0; n < LIST_DEPTH; n++)
        begin
            if ($urandom_range(0, 1) == 0)
                send_word(ilie_pkg::MODE_APPEND, 6'($urandom_range(0, 63)), $urandom());
            else
                send_word(ilie_pkg::MODE_INSERT, 6'($urandom_range(0, n)), $urandom());
        end
        send_word(ilie_pkg::MODE_APPEND,    6'd0,  32'hDEAD_0001);
        send_word(ilie_pkg::MODE_INSERT,    6'd0,  32'hDEAD_0002);
        send_word(ilie_pkg::MODE_INSERT,    6'd32, 32'hDEAD_0003);
        send_word(ilie_pkg::MODE_OVERWRITE, 6'd32, 32'hDEAD_0004);
        send_word(ilie_pkg::MODE_OVERWRITE, 6'd33, 32'hDEAD_0005);
        send_word(ilie_pkg::MODE_INSERT,    6'd40, 32'hDEAD_0006);
        send_word(ilie_pkg::MODE_OVERWRITE, 6'd31, 32'hFFFF_FFFF);
        send_word(ilie_pkg::MODE_READ,      6'd31, 32'h0);
        send_word(ilie_pkg::MODE_READ,      6'd32, 32'h0);
        send_word(ilie_pkg::MODE_ERASE,     6'd32, 32'h0);
        send_word(ilie_pkg::MODE_ERASE,     6'd31, 32'h0);
        send_word(ilie_pkg::MODE_ERASE,     6'd0,  32'h0);
        send_word(ilie_pkg::MODE_READ,      6'd0,  32'h0);
        send_word(ilie_pkg::MODE_INSERT,    6'd30, 32'h0F0F_0F0F);
        send_word(ilie_pkg::MODE_INSERT,    6'd15, 32'hF0F0_F0F0);
        send_word(ilie_pkg::MODE_APPEND,    6'd0,  32'h0);
        wait_drained();
    endtask

    // One random request word. grow biases the mix towards a longer list.
    task automatic send_random(input bit grow);
        logic [2:0] op;
        logic [5:0] pos;
        int unsigned pick;
        int          span;
        pick = $urandom_range(0, 99);
        if (pick < (grow ? 22 : 10))
            op = ilie_pkg::MODE_APPEND;
        else if (pick < 35)
            op = ilie_pkg::MODE_OVERWRITE;
        else if (pick < (grow ? 58 : 45))
            op = ilie_pkg::MODE_INSERT;
        else if (pick < 75)
            op = ilie_pkg::MODE_ERASE;
        else if (pick < 95)
            op = ilie_pkg::MODE_READ;
        else if (pick < 97)
            op = ilie_pkg::MODE_CLEAR;
        else
            op = ($urandom_range(0, 1) == 0) ? MODE_SPARE_LO : MODE_SPARE_HI;
        // Mostly in range: erase and read take below the length, the others up to it
        span = shadow_len;
        if (op == ilie_pkg::MODE_ERASE || op == ilie_pkg::MODE_READ)
            span = (shadow_len > 0) ? shadow_len - 1 : 0;
        if ($urandom_range(0, 99) < 85)
            pos = 6'($urandom_range(0, span));
        else
            pos = 6'($urandom_range(0, 63));
        send_word(op, pos, $urandom());
    endtask

    // Hold the receiver off while words keep coming, so the block backs up.
    task automatic test_backpressure();
        hold_request = 1'b1;
        for (int n = 0; n < 40; n++)
            send_random(1'b1);
        wait_drained();
    endtask

    // Random traffic in segments that vary bias and idling, with a full pause
    // after every second segment until every response word is back.
    task automatic test_random_mixed();
        for (int seg = 0; seg < 8; seg++)
        begin
            src_gaps  = (seg % 3) != 2;
            sink_gaps = (seg % 4) != 3;
            for (int n = 0; n < 90; n++)
                send_random(seg % 2 == 0);
            if (seg % 2 == 1)
                wait_drained();
        end
        wait_drained();
    endtask

    // Last stretch at full rate on both sides.
    task automatic test_random_steady();
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        for (int n = 0; n < 100; n++)
            send_random(n < 60);
    endtask

    initial
    begin
        fail_count   = 0;
        peak_len     = 0;
        shadow_len   = 0;
        src_gaps     = 1'b1;
        sink_gaps    = 1'b1;
        hold_request = 1'b0;
        foreach (mode_seen[i]) mode_seen[i] = 0;
        foreach (status_seen[i]) status_seen[i] = 0;
        foreach (shadow_list[i]) shadow_list[i] = '0;

        rst_n           <= 1'b0;
        req_if.valid    <= 1'b0;
        req_if.mode     <= ilie_pkg::MODE_READ;
        req_if.position <= '0;
        req_if.value    <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_edge_cases();
        test_full_list();
        test_backpressure();
        test_random_mixed();
        test_random_steady();
        wait_drained();
        repeat (4) @(posedge clk);

        if (pending_rsp.size() != 0)
        begin
            $error("%0d response words never arrived", pending_rsp.size());
            fail_count++;
        end

        $display("Words by mode: append %0d, overwrite %0d, insert %0d, erase %0d,",
                 mode_seen[ilie_pkg::MODE_APPEND], mode_seen[ilie_pkg::MODE_OVERWRITE],
                 mode_seen[ilie_pkg::MODE_INSERT], mode_seen[ilie_pkg::MODE_ERASE]);
        $display("  read %0d, clear %0d, spare %0d",
                 mode_seen[ilie_pkg::MODE_READ], mode_seen[ilie_pkg::MODE_CLEAR],
                 mode_seen[MODE_SPARE_LO] + mode_seen[MODE_SPARE_HI]);
        $display("Outcomes: done %0d, out of range %0d, full %0d; longest list %0d",
                 status_seen[ilie_pkg::ST_DONE], status_seen[ilie_pkg::ST_RANGE],
                 status_seen[ilie_pkg::ST_FULL], peak_len);
        $display("Mismatches %0d", fail_count);

        if (fail_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
